>>> rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared beat types and constants of the triangle face normal block.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int AXES     = 3;
    localparam int MAG_W    = 31;
    localparam int NORMAL_W = 16;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [31:0] v0_x;
        logic signed [31:0] v0_y;
        logic signed [31:0] v0_z;
        logic signed [31:0] v1_x;
        logic signed [31:0] v1_y;
        logic signed [31:0] v1_z;
        logic signed [31:0] v2_x;
        logic signed [31:0] v2_y;
        logic signed [31:0] v2_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic                       degenerate;
    } t_out_beat;

    typedef struct packed {
        logic [AXES-1:0][MAG_W-1:0] mag;
        logic [AXES-1:0]            neg;
        logic                       deg;
    } t_mid;

endpackage

>>> rtl/tfn_front.sv
// ----------------------------------------------------------------------------
// tfn_front
// Edge forming, edge reduction, cross product and cross reduction pipeline.
// ----------------------------------------------------------------------------
module tfn_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tfn_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output tfn_pkg::t_mid     o_data
);

    typedef struct packed {
        logic [2:0][61:0] m;
        logic [2:0]       neg;
        logic             deg;
    } t_cx;

    logic [9:1] r_v;
    logic       en;

    logic signed [2:0][32:0] r_e1, r_e2, n_e1, n_e2;
    logic signed [2:0][31:0] r_r1, r_r2, n_r1, n_r2;
    logic signed [5:0][63:0] r_p;
    logic signed [2:0][63:0] r_c;
    t_cx                     r_cx5, r_cx6, r_cx7, r_cx8, n_cx5;
    logic [61:0]             r_pm6, r_pm7, n_pm6;
    logic [5:0]              r_k7, n_k7, r_t8, n_t8;
    logic                    r_small7;
    tfn_pkg::t_mid           r_out, n_out;

    assign en      = !r_v[9] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_v[9];
    assign o_data  = r_out;

    function automatic logic signed [31:0] red_one(logic signed [32:0] x, logic [1:0] s);
        logic [32:0] m;
        m = x[32] ? (33'd0 - x) : x;
        m = m >> s;
        return x[32] ? (32'd0 - m[31:0]) : m[31:0];
    endfunction

    function automatic logic [1:0] red_shift(logic signed [2:0][32:0] e);
        logic [32:0] m, mx;
        mx = '0;
        for (int i = 0; i < 3; i++) begin
            m = e[i][32] ? (33'd0 - e[i]) : e[i];
            if (m > mx) mx = m;
        end
        if ((mx >> 1) > 33'h4000_0000) return 2'd2;
        if (mx > 33'h4000_0000) return 2'd1;
        return 2'd0;
    endfunction

    always_comb begin
        logic [1:0] s1, s2;
        logic [61:0] q;
        logic [5:0]  sh;
        n_e1[0] = 33'(i_data.v1_x) - 33'(i_data.v0_x);
        n_e1[1] = 33'(i_data.v1_y) - 33'(i_data.v0_y);
        n_e1[2] = 33'(i_data.v1_z) - 33'(i_data.v0_z);
        n_e2[0] = 33'(i_data.v2_x) - 33'(i_data.v0_x);
        n_e2[1] = 33'(i_data.v2_y) - 33'(i_data.v0_y);
        n_e2[2] = 33'(i_data.v2_z) - 33'(i_data.v0_z);
        s1 = red_shift(r_e1);
        s2 = red_shift(r_e2);
        for (int i = 0; i < 3; i++) begin
            n_r1[i] = red_one(r_e1[i], s1);
            n_r2[i] = red_one(r_e2[i], s2);
            n_cx5.m[i]   = r_c[i][63] ? 62'(64'd0 - r_c[i]) : r_c[i][61:0];
            n_cx5.neg[i] = r_c[i][63];
        end
        n_cx5.deg = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
        n_pm6 = r_cx5.m[0];
        if (r_cx5.m[1] > n_pm6) n_pm6 = r_cx5.m[1];
        if (r_cx5.m[2] > n_pm6) n_pm6 = r_cx5.m[2];
        n_k7 = '0;
        for (int i = 0; i < 62; i++) begin
            if (r_pm6[i]) n_k7 = 6'(i);
        end
        sh = r_k7 - 6'd30;
        q  = r_pm7 >> sh;
        if (r_small7) n_t8 = '0;
        else if (q == 62'h4000_0000) n_t8 = sh;
        else n_t8 = sh + 6'd1;
        for (int i = 0; i < 3; i++) begin
            n_out.mag[i] = 31'(r_cx8.m[i] >> r_t8);
        end
        n_out.neg = r_cx8.neg;
        n_out.deg = r_cx8.deg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[8:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1 <= n_e1;
            r_e2 <= n_e2;
            r_r1 <= n_r1;
            r_r2 <= n_r2;
            r_p[0] <= $signed(r_r1[1]) * $signed(r_r2[2]);
            r_p[1] <= $signed(r_r1[2]) * $signed(r_r2[1]);
            r_p[2] <= $signed(r_r1[2]) * $signed(r_r2[0]);
            r_p[3] <= $signed(r_r1[0]) * $signed(r_r2[2]);
            r_p[4] <= $signed(r_r1[0]) * $signed(r_r2[1]);
            r_p[5] <= $signed(r_r1[1]) * $signed(r_r2[0]);
            r_c[0] <= r_p[0] - r_p[1];
            r_c[1] <= r_p[2] - r_p[3];
            r_c[2] <= r_p[4] - r_p[5];
            r_cx5 <= n_cx5;
            r_cx6 <= r_cx5;
            r_pm6 <= n_pm6;
            r_cx7 <= r_cx6;
            r_pm7 <= r_pm6;
            r_k7  <= n_k7;
            r_small7 <= (r_pm6 <= 62'h4000_0000);
            r_cx8 <= r_cx7;
            r_t8  <= n_t8;
            r_out <= n_out;
        end
    end

endmodule

>>> rtl/tfn_queue.sv
// ----------------------------------------------------------------------------
// tfn_queue
// Short FIFO that decouples the front and back pipelines.
// ----------------------------------------------------------------------------
module tfn_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  tfn_pkg::t_mid                i_data,
    input  logic                         i_pop,
    output tfn_pkg::t_mid                o_data,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [tfn_pkg::QCNT_W-1:0]   o_count
);

    tfn_pkg::t_mid                   r_mem [tfn_pkg::QDEPTH];
    logic [tfn_pkg::QPTR_W-1:0]      r_wr, r_rd;
    logic [tfn_pkg::QCNT_W-1:0]      r_cnt;

    assign o_full  = (r_cnt == tfn_pkg::QCNT_W'(tfn_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

>>> rtl/tfn_back.sv
// ----------------------------------------------------------------------------
// tfn_back
// Squares, pipelined square root and pipelined rounding division.
// ----------------------------------------------------------------------------
module tfn_back #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_pop,
    input  tfn_pkg::t_mid      i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output tfn_pkg::t_out_beat o_data
);

    localparam int F  = NORMAL_FRAC_BITS;
    localparam int QB = F + 1;
    localparam int NW = 32 + F;
    localparam int SD = 31;

    logic en;

    logic                r_va, r_vb, r_vo;
    logic [SD:0]         r_vs;
    logic [QB:0]         r_vd;
    tfn_pkg::t_mid       r_ma, r_mb;
    logic [2:0][61:0]    r_sq;
    tfn_pkg::t_mid       r_smid [SD+1];
    logic [61:0]         r_sx   [SD+1];
    logic [33:0]         r_srem [SD+1];
    logic [30:0]         r_sroot[SD+1];
    logic [2:0]          r_dneg [QB+1];
    logic                r_ddeg [QB+1];
    logic [2:0][32:0]    r_drem [QB+1];
    logic [2:0][QB-1:0]  r_dlo  [QB+1];
    logic [2:0][QB-1:0]  r_dq   [QB+1];
    logic [30:0]         r_dlen [QB+1];
    tfn_pkg::t_out_beat  r_out, n_out;

    assign en      = !r_vo || !i_stall;
    assign o_pop   = en && i_valid;
    assign o_valid = r_vo;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vs <= '0;
            r_vd <= '0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vs <= {r_vs[SD-1:0], r_vb};
            r_vd <= {r_vd[QB-1:0], r_vs[SD]};
            r_vo <= r_vd[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ma <= i_data;
            r_mb <= r_ma;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= {31'd0, r_ma.mag[i]} * {31'd0, r_ma.mag[i]};
            end
            r_smid[0]  <= r_mb;
            r_sx[0]    <= r_sq[0] + r_sq[1] + r_sq[2];
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
        end
    end

    for (genvar j = 0; j < SD; j++) begin : g_sqrt
        logic [33:0] remsh, trial;
        assign remsh = {r_srem[j][31:0], r_sx[j][61:60]};
        assign trial = {1'b0, r_sroot[j], 2'b01};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_smid[j+1] <= r_smid[j];
                r_sx[j+1]   <= {r_sx[j][59:0], 2'b00};
                if (remsh >= trial) begin
                    r_srem[j+1]  <= remsh - trial;
                    r_sroot[j+1] <= {r_sroot[j][29:0], 1'b1};
                end else begin
                    r_srem[j+1]  <= remsh;
                    r_sroot[j+1] <= {r_sroot[j][29:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NW-1:0] num;
        if (en) begin
            r_dneg[0] <= r_smid[SD].neg;
            r_ddeg[0] <= r_smid[SD].deg;
            r_dlen[0] <= r_sroot[SD];
            for (int i = 0; i < 3; i++) begin
                num = (NW'(r_smid[SD].mag[i]) << F) + NW'(r_sroot[SD] >> 1);
                r_drem[0][i] <= 33'(num >> QB);
                r_dlo[0][i]  <= num[QB-1:0];
                r_dq[0][i]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [32:0] remsh;
            if (en) begin
                r_dneg[j+1] <= r_dneg[j];
                r_ddeg[j+1] <= r_ddeg[j];
                r_dlen[j+1] <= r_dlen[j];
                for (int i = 0; i < 3; i++) begin
                    remsh = {r_drem[j][i][31:0], r_dlo[j][i][QB-1]};
                    r_dlo[j+1][i] <= {r_dlo[j][i][QB-2:0], 1'b0};
                    if (remsh >= {2'b00, r_dlen[j]}) begin
                        r_drem[j+1][i] <= remsh - {2'b00, r_dlen[j]};
                        r_dq[j+1][i]   <= {r_dq[j][i][QB-2:0], 1'b1};
                    end else begin
                        r_drem[j+1][i] <= remsh;
                        r_dq[j+1][i]   <= {r_dq[j][i][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb begin
        logic [2:0][31:0] sv;
        for (int i = 0; i < 3; i++) begin
            sv[i] = 32'(r_dq[QB][i]);
            if (r_dneg[QB][i]) sv[i] = 32'd0 - sv[i];
            if (r_ddeg[QB]) sv[i] = '0;
        end
        n_out.normal_x   = sv[0][tfn_pkg::NORMAL_W-1:0];
        n_out.normal_y   = sv[1][tfn_pkg::NORMAL_W-1:0];
        n_out.normal_z   = sv[2][tfn_pkg::NORMAL_W-1:0];
        n_out.degenerate = r_ddeg[QB];
    end

    always_ff @(posedge i_clk) begin
        if (en) r_out <= n_out;
    end

endmodule

>>> rtl/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a Q16.16 triangle, returned in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one triangle beat per cycle while o_stall is low and returns one
// normal beat per triangle, in order. The path is nine front stages for
// edges, cross product and reduction, the queue, two stages for input and
// squares, a 32-stage square root (sum plus 31 digit steps), a
// (NORMAL_FRAC_BITS+2)-stage rounding divider and the output register. The
// front and back run on separate stalls through a four-entry queue;
// throughput is one beat per cycle when neither side stalls.
module triangle_face_normal #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tfn_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output tfn_pkg::t_out_beat o_data
);

    logic                        f_valid, q_full, q_empty, q_pop, q_push;
    tfn_pkg::t_mid               f_data, q_data;
    logic [tfn_pkg::QCNT_W-1:0]  q_count;

    assign q_push = f_valid && !q_full;

    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (f_valid),
        .i_stall (q_full),
        .o_data  (f_data)
    );

    tfn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_data),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    tfn_back #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_empty),
        .o_pop   (q_pop),
        .i_data  (q_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

`ifndef NO_ASSERTIONS
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |->
            o_data.normal_x == '0 && o_data.normal_y == '0 && o_data.normal_z == '0)
        else $error("degenerate beat with nonzero normal");

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= tfn_pkg::QCNT_W'(tfn_pkg::QDEPTH))
        else $error("queue count out of range");

    a_q_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push && !q_pop |=> q_count == $past(q_count) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule
